// ===== hdl/svd_pkg.sv =====
// ----------------------------------------------------------------------------
// svd_pkg
// Shared types and constants for the sparse vector distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package svd_pkg;

	localparam int KEY_W   = 20;
	localparam int WT_W    = 16;
	localparam int ENTRY_W = KEY_W + WT_W;
	localparam int ACC_W   = 48;
	localparam int ROOT_W  = ACC_W / 2;

	// distance mode codes
	localparam logic [1:0] MODE_DOT = 2'd0;
	localparam logic [1:0] MODE_L1  = 2'd1;
	localparam logic [1:0] MODE_L2  = 2'd2;

	// register map
	localparam logic REG_MODE = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_EX,
		ST_AC,
		ST_SQ,
		ST_OUT
	} walk_state_t;

	// one result beat
	typedef struct packed {
		logic              overflow;
		logic [ACC_W-1:0]  distance;
	} res_t;

endpackage

`default_nettype wire

// ===== hdl/sparse_vector_distance.sv =====
// ----------------------------------------------------------------------------
// sparse_vector_distance
// Loads two sparse vectors into entry stores and merge-walks them by key.
// ----------------------------------------------------------------------------
// loading: one entry beat per cycle into the store of its vector, while input is not held off
// walk: read, term and accumulate steps per visited entry pair, n1+n2 pairs at most
// L2 (any mode with bit 1 set) adds a bit-serial square root before the result
// input is held off from the last beat of the second vector until the result
// reset clears counts and mode and initialises flags; stores hold no reset and need no clearing
`default_nettype none

module sparse_vector_distance #(
	parameter int MAX_ENTRIES = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// apb configuration
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	// entry input
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [39:0]  s_tdata,   // feature_key[19:0], weight[35:20], zero pad
	input  wire logic         s_tuser,   // which_vector
	input  wire logic         s_tlast,
	// result output
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [47:0]  m_tdata,   // distance[47:0]
	output logic              m_tuser    // overflow
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int AW = $clog2(MAX_ENTRIES);

	logic [1:0]     mode_q;
	logic           cfg_wr;

	logic           f_closed_q, s_closed_q, ovf_seen_q, s_drop_q;
	logic [CW-1:0]  f_cnt_q, s_cnt_q;
	logic [CW-1:0]  f_eff, s_eff, f_next, s_next;
	logic           f_room, s_room, s_drop_next, beat, start, walk_idle;
	logic           we_a, we_b;
	logic [AW-1:0]  raddr_a, raddr_b;
	logic [svd_pkg::ENTRY_W-1:0] wdata, rdata_a, rdata_b;
	svd_pkg::res_t  res;

	// configuration register
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == svd_pkg::REG_MODE);
	assign pready = 1'b1;
	assign prdata = (paddr[2] == svd_pkg::REG_MODE) ? {30'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= svd_pkg::MODE_DOT;
		end else if (cfg_wr) begin
			mode_q <= pwdata[1:0];
		end
	end

	// load bookkeeping
	always_comb begin
		beat        = s_tvalid && s_tready;
		f_eff       = f_closed_q ? '0 : f_cnt_q;
		s_eff       = s_closed_q ? '0 : s_cnt_q;
		f_room      = f_eff < CW'(MAX_ENTRIES);
		s_room      = s_eff < CW'(MAX_ENTRIES);
		f_next      = f_room ? f_eff + 1'b1 : f_eff;
		s_next      = s_room ? s_eff + 1'b1 : s_eff;
		s_drop_next = (!s_closed_q && s_drop_q) || !s_room;
		we_a        = beat && !s_tuser && f_room;
		we_b        = beat && s_tuser && s_room;
		wdata       = s_tdata[svd_pkg::ENTRY_W-1:0];
		start       = beat && s_tuser && s_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_closed_q <= 1'b1;
			s_closed_q <= 1'b1;
			ovf_seen_q <= 1'b0;
			s_drop_q   <= 1'b0;
			f_cnt_q    <= '0;
			s_cnt_q    <= '0;
		end else if (beat) begin
			if (!s_tuser) begin
				f_cnt_q    <= f_next;
				ovf_seen_q <= (!f_closed_q && ovf_seen_q) || !f_room;
				f_closed_q <= s_tlast;
			end else begin
				s_cnt_q    <= s_next;
				s_drop_q   <= s_drop_next;
				s_closed_q <= s_tlast;
			end
		end
	end

	svd_store #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (f_eff[AW-1:0]),
		.wdata (wdata),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	svd_store #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (s_eff[AW-1:0]),
		.wdata (wdata),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	svd_walk #(.CW(CW), .AW(AW)) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.n1        (f_cnt_q),
		.n2        (s_next),
		.mode      (mode_q),
		.ovf_in    (ovf_seen_q || s_drop_next),
		.raddr_a   (raddr_a),
		.raddr_b   (raddr_b),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.idle      (walk_idle),
		.res_valid (m_tvalid),
		.res       (res),
		.res_ready (m_tready)
	);

	assign s_tready = walk_idle;
	assign m_tdata  = res.distance;
	assign m_tuser  = res.overflow;

endmodule

`default_nettype wire

// ===== hdl/svd_store.sv =====
// ----------------------------------------------------------------------------
// svd_store
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module svd_store #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [AW-1:0]                waddr,
	input  wire logic [svd_pkg::ENTRY_W-1:0]  wdata,
	input  wire logic [AW-1:0]                raddr,
	output logic      [svd_pkg::ENTRY_W-1:0]  rdata
);

	logic [svd_pkg::ENTRY_W-1:0] mem [DEPTH];
	logic [svd_pkg::ENTRY_W-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/svd_isqrt.sv =====
// ----------------------------------------------------------------------------
// svd_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module svd_isqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [svd_pkg::ACC_W-1:0]   value,
	output logic                             done,
	output logic      [svd_pkg::ROOT_W-1:0]  root
);

	localparam int RW = svd_pkg::ROOT_W + 2;
	localparam int CNT_W = $clog2(svd_pkg::ROOT_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [svd_pkg::ACC_W-1:0]   v_q;
	logic [RW-1:0]               rem_q;
	logic [svd_pkg::ROOT_W-1:0]  root_q;

	logic [RW:0]                 rem_sh;
	logic [RW:0]                 trial;
	logic                        fits;

	// one digit step
	always_comb begin
		rem_sh = {rem_q[RW-2:0], v_q[svd_pkg::ACC_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		fits   = rem_sh >= trial;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(svd_pkg::ROOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q <= {v_q[svd_pkg::ACC_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= RW'(rem_sh - trial);
				root_q <= {root_q[svd_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[RW-1:0];
				root_q <= {root_q[svd_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ===== hdl/svd_walk.sv =====
// ----------------------------------------------------------------------------
// svd_walk
// Merge walk over both stores with saturating accumulation and result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module svd_walk #(
	parameter int CW = 9,
	parameter int AW = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [CW-1:0]                n1,
	input  wire logic [CW-1:0]                n2,
	input  wire logic [1:0]                   mode,
	input  wire logic                         ovf_in,
	output logic      [AW-1:0]                raddr_a,
	output logic      [AW-1:0]                raddr_b,
	input  wire logic [svd_pkg::ENTRY_W-1:0]  rdata_a,
	input  wire logic [svd_pkg::ENTRY_W-1:0]  rdata_b,
	output logic                              idle,
	output logic                              res_valid,
	output svd_pkg::res_t                     res,
	input  wire logic                         res_ready
);

	localparam int KW = svd_pkg::KEY_W;
	localparam int WW = svd_pkg::WT_W;
	localparam int AccW = svd_pkg::ACC_W;

	svd_pkg::walk_state_t state_q, state_d;

	logic [CW-1:0]           i_q, j_q, n1_q, n2_q;
	logic [1:0]              mode_q;
	logic                    ovf_q, sat_q;
	logic signed [AccW-1:0]  acc_q;
	logic signed [AccW-1:0]  term_s1;
	logic                    res_valid_q;
	svd_pkg::res_t           res_q;

	logic                    a_ok, b_ok, both, take_a;
	logic [KW-1:0]           ka, kb;
	logic signed [WW-1:0]    wa, wb;
	logic signed [WW:0]      d, mx, my;
	logic signed [2*WW+1:0]  prod;
	logic [WW+1:0]           d_abs;
	logic signed [AccW-1:0]  term_d;
	logic signed [AccW:0]    sum;
	logic                    sq_start, sq_done;
	logic [svd_pkg::ROOT_W-1:0] sq_root;

	// term from the current pair of entries
	always_comb begin
		ka     = rdata_a[KW-1:0];
		kb     = rdata_b[KW-1:0];
		wa     = rdata_a[svd_pkg::ENTRY_W-1:KW];
		wb     = rdata_b[svd_pkg::ENTRY_W-1:KW];
		a_ok   = i_q < n1_q;
		b_ok   = j_q < n2_q;
		both   = a_ok && b_ok && (ka == kb);
		take_a = a_ok && (!b_ok || (ka < kb));
		if (both) begin
			d = (WW+1)'(wa) - (WW+1)'(wb);
		end else if (take_a) begin
			d = (WW+1)'(wa);
		end else begin
			d = (WW+1)'(wb);
		end
		if (mode_q == svd_pkg::MODE_DOT) begin
			mx = (WW+1)'(wa);
			my = (WW+1)'(wb);
		end else begin
			mx = d;
			my = d;
		end
		prod  = mx * my;
		d_abs = d[WW] ? (WW+2)'(-{d[WW], d}) : (WW+2)'({d[WW], d});
		case (mode_q)
			svd_pkg::MODE_DOT: term_d = both ? AccW'(prod) : '0;
			svd_pkg::MODE_L1:  term_d = AccW'(d_abs);
			default:           term_d = AccW'(prod);
		endcase
		sum = {acc_q[AccW-1], acc_q} + {term_s1[AccW-1], term_s1};
	end

	// next state
	always_comb begin
		state_d  = state_q;
		sq_start = 1'b0;
		case (state_q)
			svd_pkg::ST_IDLE: begin
				if (start) state_d = svd_pkg::ST_RD;
			end
			svd_pkg::ST_RD: begin
				if ((i_q < n1_q) || (j_q < n2_q)) begin
					state_d = svd_pkg::ST_EX;
				end else if (mode_q[1]) begin
					state_d  = svd_pkg::ST_SQ;
					sq_start = 1'b1;
				end else begin
					state_d = svd_pkg::ST_OUT;
				end
			end
			svd_pkg::ST_EX: state_d = svd_pkg::ST_AC;
			svd_pkg::ST_AC: state_d = svd_pkg::ST_RD;
			svd_pkg::ST_SQ: begin
				if (sq_done) state_d = svd_pkg::ST_OUT;
			end
			svd_pkg::ST_OUT: begin
				if (!res_valid_q || res_ready) state_d = svd_pkg::ST_IDLE;
			end
			default: state_d = svd_pkg::ST_IDLE;
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= svd_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == svd_pkg::ST_OUT && state_d == svd_pkg::ST_IDLE) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			svd_pkg::ST_IDLE: begin
				if (start) begin
					i_q    <= '0;
					j_q    <= '0;
					n1_q   <= n1;
					n2_q   <= n2;
					mode_q <= mode;
					ovf_q  <= ovf_in;
					acc_q  <= '0;
					sat_q  <= 1'b0;
				end
			end
			svd_pkg::ST_EX: begin
				term_s1 <= term_d;
				if (both || take_a) i_q <= i_q + 1'b1;
				if (both || !take_a) j_q <= j_q + 1'b1;
			end
			svd_pkg::ST_AC: begin
				if (sum[AccW] != sum[AccW-1]) begin
					acc_q <= sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
					sat_q <= 1'b1;
				end else begin
					acc_q <= sum[AccW-1:0];
				end
			end
			svd_pkg::ST_OUT: begin
				if (!res_valid_q || res_ready) begin
					res_q.overflow <= ovf_q | sat_q;
					res_q.distance <= mode_q[1] ? AccW'(sq_root) : acc_q;
				end
			end
			default: ;
		endcase
	end

	svd_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (acc_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	assign raddr_a   = i_q[AW-1:0];
	assign raddr_b   = j_q[AW-1:0];
	assign idle      = state_q == svd_pkg::ST_IDLE;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== hdl/svd_checker.sv =====
// ----------------------------------------------------------------------------
// svd_checker
// Port-level checks on the sparse vector distance block.
// ----------------------------------------------------------------------------
`default_nettype none

module svd_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         pready,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic         s_tuser,
	input  wire logic         s_tlast,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [47:0]  m_tdata
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// last beat of the second vector starts the walk and stops input
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser && s_tlast |=> !s_tready)
		else $error("input still taken after walk start");

	// a new result only appears at the end of a walk
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result without a walk");

	// configuration port never stalls
	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind sparse_vector_distance svd_checker u_svd_checker (.*);

`default_nettype wire

// ===== tb/sv/sparse_vector_distance_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_vector_distance_tb
// Streams pairs of sparse vectors into the block under all distance modes,
// predicts each distance and overflow flag with a behavioural merge walk and
// compares every result beat in order, under random source and sink idling.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_vector_distance_tb;

	localparam int NSTORE = 256;
	localparam int WATCH_LIMIT = 200000;

	typedef struct {
		logic [19:0] key;
		logic signed [15:0] wt;
	} entry_t;

	typedef struct {
		logic [47:0] distance;
		logic        overflow;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic m_tuser;

	sparse_vector_distance dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #6 clk = ~clk;

	// predictor state
	entry_t first_vec[NSTORE];
	entry_t second_vec[NSTORE];
	int unsigned first_n, second_n;
	bit first_done = 1'b1, second_done = 1'b1;
	bit first_lost, second_lost;
	logic [1:0] mode_q = svd_pkg::MODE_DOT;
	result_t distance_q[$];

	int errors;
	int src_idle_pct, snk_stall_pct;
	bit sink_hold;
	int quiet_cycles;

	task automatic report(input string what);
		$display("error at %0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic logic [47:0] root48(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r[47:0];
	endfunction

	// saturating accumulate into the signed 48-bit range
	function automatic void sat_add(inout longint acc, inout bit sat, input longint t);
		longint s;
		s = acc + t;
		if (s > 64'sh7FFF_FFFF_FFFF) begin
			s = 64'sh7FFF_FFFF_FFFF;
			sat = 1;
		end
		if (s < -64'sh8000_0000_0000) begin
			s = -64'sh8000_0000_0000;
			sat = 1;
		end
		acc = s;
	endfunction

	function automatic void add_term(inout longint acc, inout bit sat, input bit matched,
			input longint a, input longint b);
		longint d;
		d = matched ? a - b : a;
		if (mode_q == svd_pkg::MODE_DOT) begin
			if (matched) sat_add(acc, sat, a * b);
		end else if (mode_q == svd_pkg::MODE_L1) begin
			sat_add(acc, sat, d < 0 ? -d : d);
		end else begin
			sat_add(acc, sat, d * d);
		end
	endfunction

	function automatic result_t merge_distance();
		int unsigned i, j;
		longint acc;
		bit sat;
		result_t r;
		i = 0; j = 0; acc = 0; sat = 0;
		while (i < first_n && j < second_n) begin
			if (first_vec[i].key < second_vec[j].key) begin
				add_term(acc, sat, 0, first_vec[i].wt, 0); i++;
			end else if (second_vec[j].key < first_vec[i].key) begin
				add_term(acc, sat, 0, second_vec[j].wt, 0); j++;
			end else begin
				add_term(acc, sat, 1, first_vec[i].wt, second_vec[j].wt);
				i++; j++;
			end
		end
		while (i < first_n) begin add_term(acc, sat, 0, first_vec[i].wt, 0); i++; end
		while (j < second_n) begin add_term(acc, sat, 0, second_vec[j].wt, 0); j++; end
		if (mode_q != svd_pkg::MODE_DOT && mode_q != svd_pkg::MODE_L1)
			acc = longint'(root48(acc));
		r.distance = acc[47:0];
		r.overflow = first_lost | second_lost | sat;
		return r;
	endfunction

	// fold one accepted entry beat into the predictor
	function automatic void absorb_entry(input bit sec, input logic [19:0] key,
			input logic [15:0] wt, input bit lst);
		if (!sec) begin
			if (first_done) begin first_n = 0; first_done = 0; first_lost = 0; end
			if (first_n < NSTORE) begin
				first_vec[first_n] = '{key, wt}; first_n++;
			end else first_lost = 1;
			if (lst) first_done = 1;
		end else begin
			if (second_done) begin second_n = 0; second_done = 0; second_lost = 0; end
			if (second_n < NSTORE) begin
				second_vec[second_n] = '{key, wt}; second_n++;
			end else second_lost = 1;
			if (lst) begin
				second_done = 1;
				distance_q.insert(distance_q.size(), merge_distance());
			end
		end
	endfunction

	// send one entry beat, with random source idling before it
	task automatic send_entry(input bit sec, input logic [19:0] key,
			input logic [15:0] wt, input bit lst);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= sec;
		s_tlast  <= lst;
		s_tdata  <= {4'b0, wt, key};
		do @(posedge clk); while (!s_tready);
		absorb_entry(sec, key, wt, lst);
		@(negedge clk);
	endtask

	// source goes quiet until every expected result has come
	task automatic drain();
		s_tvalid <= 1'b0;
		while (distance_q.size() != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic write_mode(input logic [1:0] m);
		drain();
		psel <= 1; pwrite <= 1; paddr <= {svd_pkg::REG_MODE, 2'b00}; pwdata <= {30'b0, m};
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		mode_q = m;
		@(negedge clk);
		if (prdata[1:0] !== m) report("mode register read back wrong");
	endtask

	// random vector with mostly ascending keys, mostly in a narrow key range
	task automatic send_vector(input bit sec, input int n, input bit wide);
		logic [19:0] key;
		logic [15:0] wt;
		int span;
		span = wide ? 4000 : 3;
		key = 20'($urandom_range(wide ? 1000 : 8));
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(9))
				0: wt = 16'h8000;
				1: wt = 16'h7FFF;
				default: wt = 16'($urandom);
			endcase
			if ($urandom_range(19) == 0) key = 20'($urandom);
			send_entry(sec, key, wt, k == n - 1);
			key = 20'(key + 1 + $urandom_range(span));
		end
	endtask

	task automatic test_directed();
		for (int m = 0; m < 4; m++) begin
			write_mode(m[1:0]);
			send_entry(0, 20'h00000, 16'h8000, 0);
			send_entry(0, 20'h00005, 16'h7FFF, 0);
			send_entry(0, 20'hFFFFF, 16'h7FFF, 1);
			send_entry(1, 20'h00000, 16'h7FFF, 0);
			send_entry(1, 20'h00004, 16'h8000, 0);
			send_entry(1, 20'hFFFFF, 16'h8000, 1);
			send_entry(1, 20'h00003, 16'h0001, 1);
		end
	endtask

	// full stores and dropped entries
	task automatic test_store_full();
		write_mode(svd_pkg::MODE_L2);
		for (int k = 0; k < 260; k++) send_entry(0, 20'(k), 16'h8000, k == 259);
		for (int k = 0; k < 258; k++) send_entry(1, 20'(k + 300), 16'h7FFF, k == 257);
		write_mode(svd_pkg::MODE_DOT);
		send_vector(1, 256, 0);
		write_mode(svd_pkg::MODE_L1);
		send_vector(0, 20, 0);
		send_vector(1, 30, 0);
	endtask

	task automatic test_random(input int items);
		int sent;
		sent = 0;
		while (sent < items) begin
			int n1, n2;
			if ($urandom_range(9) == 0) write_mode(2'($urandom_range(3)));
			n1 = $urandom_range(1, 12);
			if ($urandom_range(3) != 0) begin
				send_vector(0, n1, $urandom_range(3) == 0);
				sent += n1;
			end
			for (int r = $urandom_range(1, 3); r > 0; r--) begin
				n2 = $urandom_range(1, 12);
				send_vector(1, n2, $urandom_range(3) == 0);
				sent += n2;
			end
		end
	endtask

	task automatic test_backpressure();
		sink_hold = 1;
		send_vector(1, 5, 0);
		send_vector(1, 5, 0);
		send_vector(0, 6, 0);
		drain();
	endtask

	// result checker
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (distance_q.size() == 0) begin
				report("result beat with nothing expected");
			end else begin
				result_t e;
				e = distance_q.pop_front();
				if (m_tdata !== e.distance)
					report($sformatf("distance %h, predicted %h", m_tdata, e.distance));
				if (m_tuser !== e.overflow)
					report($sformatf("overflow %b, predicted %b", m_tuser, e.overflow));
			end
		end
	end

	// sink stalling, with a long hold-off on request
	always @(negedge clk) begin
		if (sink_hold) begin
			m_tready <= 1'b0;
			repeat (400) @(negedge clk);
			sink_hold = 0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// watchdog on cycles with no accepted beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		errors = 0;
		quiet_cycles = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		sink_hold = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_store_full();
		test_backpressure();
		test_random(240);
		src_idle_pct = 46;
		test_random(200);
		src_idle_pct = 0; snk_stall_pct = 46;
		test_random(200);
		src_idle_pct = 34; snk_stall_pct = 34;
		test_random(200);
		drain();
		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/svd_pkg.sv
hdl/svd_store.sv
hdl/svd_isqrt.sv
hdl/svd_walk.sv
hdl/sparse_vector_distance.sv
hdl/svd_checker.sv
tb/sv/sparse_vector_distance_tb.sv
